>>> rtl/core/mcsp_pkg.sv
// Shared types and constants of the minimum-cost simple path search.
// Used by the controller, the datapath and the top level.
package mcsp_pkg;

  localparam int unsigned NODES   = 8;
  localparam int unsigned VERT_W  = 3;
  localparam int unsigned NEXT_W  = $clog2(NODES + 1);
  localparam int unsigned EADDR_W = 2 * VERT_W;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned COST_W  = 19;
  localparam int unsigned SP_W    = $clog2(NODES);

  typedef enum logic [1:0] {
    ACT_SET    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DST_RD,
    ST_POP_RD,
    ST_FINISH
  } state_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_SET,
    DP_REMOVE,
    DP_START,
    DP_TRIVIAL,
    DP_STEP,
    DP_PUSH,
    DP_RD_DST,
    DP_OFFER_DST,
    DP_POP,
    DP_RD_POP,
    DP_POP_OFFER,
    DP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic nb_done;
    logic sp_zero;
    logic cur_found;
    logic edge_ok;
    logic is_dst;
    logic src_eq_dst;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [VERT_W-1:0]        vertex;
    logic [NEXT_W-1:0]        next;
    logic signed [COST_W-1:0] best;
    logic                     found;
  } frame_t;

endpackage

>>> rtl/core/mcsp_ctrl.sv
// Sequencer of the search: decodes transactions and walks the DFS steps.
// Depends on mcsp_pkg; drives the datapath mcsp_dp through dp_cmd_t.
module mcsp_ctrl
  import mcsp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  action_e    action_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = DP_NOP;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (action_i)
            ACT_SET:    cmd_o.op = DP_SET;
            ACT_REMOVE: cmd_o.op = DP_REMOVE;
            ACT_QUERY: begin
              if (status_i.src_eq_dst) begin
                cmd_o.op = DP_TRIVIAL;
              end else begin
                cmd_o.op = DP_START;
              end
              state_d = status_i.src_eq_dst ? ST_FINISH : ST_SCAN;
            end
            default: cmd_o.op = DP_NOP;
          endcase
        end
      end
      ST_SCAN: begin
        if (status_i.nb_done) begin
          if (status_i.sp_zero) begin
            state_d = ST_FINISH;
          end else if (status_i.cur_found) begin
            cmd_o.op = DP_RD_POP;
            state_d  = ST_POP_RD;
          end else begin
            cmd_o.op = DP_POP;
          end
        end else if (!status_i.edge_ok) begin
          cmd_o.op = DP_STEP;
        end else if (status_i.is_dst) begin
          cmd_o.op = DP_RD_DST;
          state_d  = ST_DST_RD;
        end else begin
          cmd_o.op = DP_PUSH;
        end
      end
      ST_DST_RD: begin
        cmd_o.op = DP_OFFER_DST;
        state_d  = ST_SCAN;
      end
      ST_POP_RD: begin
        cmd_o.op = DP_POP_OFFER;
        state_d  = ST_SCAN;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.op = DP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/mcsp_dp.sv
// Datapath: adjacency matrix, visited marks, frame stack and result register.
// Depends on mcsp_pkg; commanded by mcsp_ctrl.
module mcsp_dp
  import mcsp_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_t                    cmd_i,
  output dp_status_t                 status_o,
  input  logic [VERT_W-1:0]          from_node_i,
  input  logic [VERT_W-1:0]          to_node_i,
  input  logic signed [WEIGHT_W-1:0] weight_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [COST_W-1:0]   path_cost_o,
  output logic                       path_found_o
);

  logic [WEIGHT_W-1:0]       cost_mem [NODES*NODES];
  logic [WEIGHT_W-1:0]       mem_rdata_q;
  logic [EADDR_W-1:0]        rd_addr;
  logic [NODES*NODES-1:0]    present_q;
  logic [NODES-1:0]          visited_q;
  logic [SP_W-1:0]           sp_q;
  logic [VERT_W-1:0]         dst_q;
  frame_t                    cur_q;
  frame_t                    stack_q [NODES];
  frame_t                    parent;
  frame_t                    push_frame;
  frame_t                    offer_frame;
  logic [SP_W-1:0]           sp_dec;
  logic [VERT_W-1:0]         nb;
  logic signed [COST_W-1:0]  w_ext;
  logic signed [COST_W-1:0]  cand_pop;
  logic                      out_valid_q;
  logic signed [COST_W-1:0]  out_cost_q;
  logic                      out_found_q;

  assign sp_dec   = sp_q - 1'b1;
  assign parent   = stack_q[sp_dec];
  assign nb       = cur_q.next[VERT_W-1:0];
  assign w_ext    = {{(COST_W-WEIGHT_W){mem_rdata_q[WEIGHT_W-1]}}, mem_rdata_q};
  assign cand_pop = w_ext + cur_q.best;
  assign rd_addr  = (cmd_i.op == DP_RD_POP) ? {parent.vertex, cur_q.vertex}
                                            : {cur_q.vertex, nb};

  always_comb begin
    push_frame      = cur_q;
    push_frame.next = cur_q.next + 1'b1;
    offer_frame     = parent;
    if (!parent.found || (cand_pop < parent.best)) begin
      offer_frame.best  = cand_pop;
      offer_frame.found = 1'b1;
    end
  end

  assign status_o.nb_done    = (cur_q.next == NEXT_W'(NODES));
  assign status_o.sp_zero    = (sp_q == '0);
  assign status_o.cur_found  = cur_q.found;
  assign status_o.edge_ok    = present_q[{cur_q.vertex, nb}] && !visited_q[nb];
  assign status_o.is_dst     = (nb == dst_q);
  assign status_o.src_eq_dst = (from_node_i == to_node_i);
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_SET) begin
      cost_mem[{from_node_i, to_node_i}] <= weight_i;
    end
    mem_rdata_q <= cost_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= '0;
      visited_q   <= '0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == DP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        DP_SET:    present_q[{from_node_i, to_node_i}] <= 1'b1;
        DP_REMOVE: present_q[{from_node_i, to_node_i}] <= 1'b0;
        DP_START: begin
          visited_q <= NODES'(1) << from_node_i;
          sp_q      <= '0;
        end
        DP_PUSH: begin
          visited_q[nb] <= 1'b1;
          sp_q          <= sp_q + 1'b1;
        end
        DP_POP, DP_POP_OFFER: begin
          visited_q[cur_q.vertex] <= 1'b0;
          sp_q                    <= sp_dec;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_START: begin
        dst_q        <= to_node_i;
        cur_q.vertex <= from_node_i;
        cur_q.next   <= '0;
        cur_q.best   <= '0;
        cur_q.found  <= 1'b0;
      end
      DP_TRIVIAL: begin
        cur_q.best  <= '0;
        cur_q.found <= 1'b1;
      end
      DP_STEP, DP_RD_DST: cur_q.next <= cur_q.next + 1'b1;
      DP_PUSH: begin
        stack_q[sp_q] <= push_frame;
        cur_q.vertex  <= nb;
        cur_q.next    <= '0;
        cur_q.best    <= '0;
        cur_q.found   <= 1'b0;
      end
      DP_OFFER_DST: begin
        if (!cur_q.found || (w_ext < cur_q.best)) begin
          cur_q.best  <= w_ext;
          cur_q.found <= 1'b1;
        end
      end
      DP_POP: cur_q <= parent;
      DP_POP_OFFER: cur_q <= offer_frame;
      DP_EMIT: begin
        out_cost_q  <= cur_q.found ? cur_q.best : '0;
        out_found_q <= cur_q.found;
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign path_cost_o  = out_cost_q;
  assign path_found_o = out_found_q;

endmodule

>>> rtl/core/min_cost_simple_path_search.sv
// Minimum-cost simple path search over an 8-vertex directed weighted graph.
// Set and remove transactions are applied without leaving idle; a query yields one result
// transaction and holds off new input until its search ends. The search walks
// every simple path by depth-first backtracking: it accepts the query, then for
// each vertex placed on the path it examines each candidate neighbor and returns
// from it, takes an extra step per destination hit and per return from a vertex
// that reached the destination, and finally loads the result register, which can
// wait while an earlier result is stalled. The search time therefore grows with
// the number of simple paths; source equal to destination skips the search and
// goes straight to loading the result.
// Depends on mcsp_pkg, mcsp_ctrl and mcsp_dp.
module min_cost_simple_path_search
  import mcsp_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 action_i,
  input  logic [VERT_W-1:0]          from_node_i,
  input  logic [VERT_W-1:0]          to_node_i,
  input  logic signed [WEIGHT_W-1:0] weight_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [COST_W-1:0]   path_cost_o,
  output logic                       path_found_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mcsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_e'(action_i)),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mcsp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .from_node_i  (from_node_i),
    .to_node_i    (to_node_i),
    .weight_i     (weight_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .path_cost_o  (path_cost_o),
    .path_found_o (path_found_o)
  );

endmodule

>>> tb/tb_min_cost_simple_path_search.sv
// Self-checking testbench for min_cost_simple_path_search: graph edits and
// path queries are driven with random bursts and gaps, and every query result
// is checked against a behavioral DFS search. Depends on mcsp_pkg and the RTL.
module tb_min_cost_simple_path_search;
  timeunit 1ns;
  timeprecision 1ps;

  import mcsp_pkg::*;

  typedef struct {
    action_e                    act;
    logic [VERT_W-1:0]          src;
    logic [VERT_W-1:0]          dst;
    logic signed [WEIGHT_W-1:0] w;
  } graph_op_t;

  typedef struct {
    logic signed [COST_W-1:0] cost;
    logic                     found;
  } path_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [1:0]                 action_i = ACT_NONE;
  logic [VERT_W-1:0]          from_node_i = '0;
  logic [VERT_W-1:0]          to_node_i = '0;
  logic signed [WEIGHT_W-1:0] weight_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [COST_W-1:0]   path_cost_o;
  logic                       path_found_o;

  graph_op_t    pending_ops_q[$];
  path_result_t path_results_q[$];
  graph_op_t    cur_op;
  path_result_t want_res;

  logic signed [WEIGHT_W-1:0] edge_w[NODES*NODES];
  bit                         edge_on[NODES*NODES];
  bit                         plan_on[NODES*NODES];
  int                         plan_cnt = 0;

  int     error_cnt = 0;
  longint work_budget = 0;
  longint cycle_cnt = 0;
  int     gap_left = 0;
  int     burst_left = 1;
  int     stall_mode = 0;
  int     stall_left = 0;

  min_cost_simple_path_search u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .from_node_i  (from_node_i),
    .to_node_i    (to_node_i),
    .weight_i     (weight_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .path_cost_o  (path_cost_o),
    .path_found_o (path_found_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Exhaustive backtracking search over simple paths; steps estimates cycles.
  function automatic void find_cheapest_path(input logic [VERT_W-1:0] src,
                                             input logic [VERT_W-1:0] dst,
                                             output bit found, output longint cost,
                                             output int steps);
    int          vtx[NODES];
    int          nxt[NODES];
    longint      best[NODES];
    bit          have[NODES];
    bit [NODES-1:0] on_path;
    int          sp;
    int          v;
    int          i;
    longint      cand;
    found = 1'b0;
    cost = 0;
    steps = 2;
    if (src == dst) begin
      found = 1'b1;
      return;
    end
    on_path = '0;
    on_path[src] = 1'b1;
    sp = 0;
    vtx[0] = src;
    nxt[0] = 0;
    best[0] = 0;
    have[0] = 1'b0;
    while (sp >= 0) begin
      steps++;
      v = vtx[sp];
      i = nxt[sp];
      if (i >= NODES) begin
        on_path[v] = 1'b0;
        if (sp == 0) begin
          found = have[0];
          if (found) cost = best[0];
          return;
        end
        if (have[sp]) begin
          steps += 2;
          cand = longint'(edge_w[vtx[sp-1]*NODES + v]) + best[sp];
          if (!have[sp-1] || cand < best[sp-1]) begin
            best[sp-1] = cand;
            have[sp-1] = 1'b1;
          end
        end
        sp--;
      end else begin
        nxt[sp] = i + 1;
        if (edge_on[v*NODES + i] && !on_path[i]) begin
          if (i == dst) begin
            steps += 2;
            cand = longint'(edge_w[v*NODES + i]);
            if (!have[sp] || cand < best[sp]) begin
              best[sp] = cand;
              have[sp] = 1'b1;
            end
          end else begin
            sp++;
            on_path[i] = 1'b1;
            vtx[sp] = i;
            nxt[sp] = 0;
            best[sp] = 0;
            have[sp] = 1'b0;
          end
        end
      end
    end
  endfunction

  function automatic void apply_graph_op(graph_op_t op);
    path_result_t res;
    bit           hit;
    longint       sum;
    int           steps;
    case (op.act)
      ACT_SET: begin
        edge_w[{op.src, op.dst}] = op.w;
        edge_on[{op.src, op.dst}] = 1'b1;
      end
      ACT_REMOVE: edge_on[{op.src, op.dst}] = 1'b0;
      ACT_QUERY: begin
        find_cheapest_path(op.src, op.dst, hit, sum, steps);
        res.cost = hit ? sum[COST_W-1:0] : '0;
        res.found = hit;
        path_results_q.push_back(res);
        work_budget += steps;
      end
      default: ;
    endcase
  endfunction

  function automatic void plan_op(action_e act, int src, int dst, int w);
    graph_op_t op;
    op.act = act;
    op.src = src[VERT_W-1:0];
    op.dst = dst[VERT_W-1:0];
    op.w = w[WEIGHT_W-1:0];
    if (act == ACT_SET && !plan_on[src*NODES + dst]) begin
      plan_on[src*NODES + dst] = 1'b1;
      plan_cnt++;
    end
    if (act == ACT_REMOVE && plan_on[src*NODES + dst]) begin
      plan_on[src*NODES + dst] = 1'b0;
      plan_cnt--;
    end
    pending_ops_q.push_back(op);
  endfunction

  function automatic void plan_remove_existing();
    int idx;
    idx = $urandom_range(0, NODES*NODES-1);
    while (!plan_on[idx]) idx = $urandom_range(0, NODES*NODES-1);
    plan_op(ACT_REMOVE, idx / NODES, idx % NODES, $urandom_range(0, 16'hFFFF));
  endfunction

  // Sender: bursts of transactions separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
      burst_left = 1;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) apply_graph_op(cur_op);
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_ops_q.size() != 0) begin
        cur_op = pending_ops_q.pop_front();
        action_i <= cur_op.act;
        from_node_i <= cur_op.src;
        to_node_i <= cur_op.dst;
        weight_i <= cur_op.w;
        in_valid_i <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 3) == 0) begin
            gap_left = 0;
            burst_left = $urandom_range(10, 30);
          end else begin
            gap_left = $urandom_range(1, 12);
            burst_left = $urandom_range(1, 6);
          end
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern switches between free, random and mostly stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(10, 60);
      end
      stall_left--;
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= 1'($urandom_range(0, 1));
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (path_results_q.size() == 0) begin
        $error("unexpected result: path_cost %0d path_found %0b", path_cost_o, path_found_o);
        error_cnt++;
      end else begin
        want_res = path_results_q.pop_front();
        if (path_cost_o !== want_res.cost) begin
          $error("path_cost mismatch: expected %0d, actual %0d", want_res.cost, path_cost_o);
          error_cnt++;
        end
        if (path_found_o !== want_res.found) begin
          $error("path_found mismatch: expected %0b, actual %0b", want_res.found,
                 path_found_o);
          error_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > 200000 + 4 * work_budget) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int k;
    int r;
    int made;
    plan_op(ACT_QUERY, 0, 0, 0);
    plan_op(ACT_QUERY, 0, 7, 0);
    plan_op(ACT_NONE, 5, 2, 16'h1234);
    plan_op(ACT_SET, 3, 3, 5);
    for (k = 0; k < 7; k++) plan_op(ACT_SET, k, k + 1, -32768);
    plan_op(ACT_QUERY, 0, 7, 0);
    for (k = 7; k > 0; k--) plan_op(ACT_SET, k, k - 1, 32767);
    plan_op(ACT_QUERY, 7, 0, 0);
    plan_op(ACT_SET, 6, 5, -1);
    plan_op(ACT_QUERY, 7, 0, 0);
    plan_op(ACT_REMOVE, 6, 5, 16'hFFFF);
    plan_op(ACT_QUERY, 7, 0, 0);
    plan_op(ACT_QUERY, 3, 4, 0);

    made = 0;
    while (made < 100) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        plan_op(ACT_NONE, $urandom_range(0, 7), $urandom_range(0, 7),
                $urandom_range(0, 16'hFFFF));
      end else begin
        made++;
        if (r < 40) begin
          plan_op(ACT_QUERY, $urandom_range(0, 7), $urandom_range(0, 7),
                  $urandom_range(0, 16'hFFFF));
        end else if (r < 55 || plan_cnt >= 30) begin
          if (plan_cnt > 0 && $urandom_range(0, 4) != 0) plan_remove_existing();
          else plan_op(ACT_REMOVE, $urandom_range(0, 7), $urandom_range(0, 7),
                       $urandom_range(0, 16'hFFFF));
        end else begin
          case ($urandom_range(0, 9))
            0: plan_op(ACT_SET, $urandom_range(0, 7), $urandom_range(0, 7), 32767);
            1: plan_op(ACT_SET, $urandom_range(0, 7), $urandom_range(0, 7), -32768);
            default: plan_op(ACT_SET, $urandom_range(0, 7), $urandom_range(0, 7),
                             $urandom_range(0, 16'hFFFF));
          endcase
        end
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending_ops_q.size() != 0 || in_valid_i || path_results_q.size() != 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/mcsp_pkg.sv
rtl/core/mcsp_ctrl.sv
rtl/core/mcsp_dp.sv
rtl/core/min_cost_simple_path_search.sv
tb/tb_min_cost_simple_path_search.sv
